FILE: hdl/hsfr_pkg.sv
package hsfr_pkg;

  // Widths fixed by the byte stream and the result format
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosOutW  = 6;
  localparam int unsigned KindW    = 2;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned ApbDataW = 32;

  // Default frame length, header and checksum byte included
  localparam int unsigned FrameLenDef = 16;

  // Register reset values
  localparam logic [ByteW-1:0] HeaderByteRst = 8'hA5;
  localparam logic [ByteW-1:0] WriteCodeRst  = 8'h52;
  localparam logic [ByteW-1:0] ReadCodeRst   = 8'h51;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE    = 2'd0,
    KIND_READ     = 2'd1,
    KIND_OTHER    = 2'd2,
    KIND_CSUM_ERR = 2'd3
  } frame_kind_e;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_HEADER     = 2'd0,
    REG_WRITE_CODE = 2'd1,
    REG_READ_CODE  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ST_RECV,
    ST_DUMP
  } rx_state_e;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] write_code;
    logic [ByteW-1:0] read_code;
  } hsfr_cfg_t;

  // Frame kind from byte 1; write code wins when both codes match
  function automatic frame_kind_e classify(input logic [ByteW-1:0] cmd,
                                           input hsfr_cfg_t cfg);
    frame_kind_e kind;
    if (cmd == cfg.write_code) begin
      kind = KIND_WRITE;
    end else if (cmd == cfg.read_code) begin
      kind = KIND_READ;
    end else begin
      kind = KIND_OTHER;
    end
    return kind;
  endfunction

endpackage

FILE: hdl/hsfr_rx_if.sv
interface hsfr_rx_if import hsfr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/hsfr_res_if.sv
interface hsfr_res_if import hsfr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   frame_byte;
  logic [PosOutW-1:0] byte_position;
  logic [KindW-1:0]   frame_kind;
  logic               last;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_kind, output last, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input frame_kind, input last, output ready);
endinterface

FILE: hdl/hsfr_cfg_regs.sv
module hsfr_cfg_regs import hsfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output hsfr_cfg_t           cfg_o
);

  hsfr_cfg_t cfg_q;
  hsfr_cfg_t cfg_d;
  reg_idx_e  reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_o   = cfg_q;

  // write decode; unmapped index is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_HEADER:     cfg_d.header_byte = pwdata[ByteW-1:0];
        REG_WRITE_CODE: cfg_d.write_code  = pwdata[ByteW-1:0];
        REG_READ_CODE:  cfg_d.read_code   = pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= HeaderByteRst;
      cfg_q.write_code  <= WriteCodeRst;
      cfg_q.read_code   <= ReadCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HEADER:     prdata = ApbDataW'(cfg_q.header_byte);
      REG_WRITE_CODE: prdata = ApbDataW'(cfg_q.write_code);
      REG_READ_CODE:  prdata = ApbDataW'(cfg_q.read_code);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: hdl/header_sum_checked_frame_receiver.sv
// Receives a byte stream and picks out fixed-length frames of FRAME_LEN bytes:
// a header byte, FRAME_LEN-2 further bytes and an 8-bit wrapping additive
// checksum over all bytes before it. While waiting for a frame every byte other
// than the header is dropped. Frame bytes go into a single-port frame store,
// and ordinary bytes are taken back to back. On a good checksum the stored
// bytes are replayed in order, each tagged with its index, the frame kind
// (write, read or other, decided from byte 1) and a last mark; each replayed
// request is first read from the store, then loaded into the output register
// once it is free, and no byte is taken during the replay. A bad checksum
// gives a single error request. The checksum byte is held off while an
// earlier request still sits in the output register.
// The frame store needs no clearing after reset.
module header_sum_checked_frame_receiver import hsfr_pkg::*; #(
  parameter int unsigned FRAME_LEN = FrameLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsfr_rx_if.sink             rx,
  hsfr_res_if.source          res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned StoreLen = FRAME_LEN - 1;
  localparam int unsigned PosW     = $clog2(FRAME_LEN);
  localparam int unsigned AddrW    = $clog2(StoreLen);
  localparam logic [PosW-1:0]  PosCsum = PosW'(StoreLen);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(StoreLen - 1);

  hsfr_cfg_t cfg;

  rx_state_e        state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] byte1_q, byte1_d;
  frame_kind_e      kind_q, kind_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             rd_pend_q, rd_pend_d;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic [AddrW-1:0] out_pos_q, out_pos_d;
  frame_kind_e      out_kind_q, out_kind_d;
  logic             out_last_q, out_last_d;

  logic [ByteW-1:0] store_mem [StoreLen];
  logic [ByteW-1:0] rd_data_q;
  logic             mem_wr_en;
  logic             mem_rd_en;

  logic rx_acc;
  logic csum_step;
  logic csum_ok;
  logic hdr_ok;
  logic out_free;

  hsfr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rx_acc    = rx.valid & rx.ready;
  assign csum_step = (pos_q == PosCsum);
  assign csum_ok   = (sum_q == rx.rx_byte);
  assign hdr_ok    = (rx.rx_byte == cfg.header_byte);
  assign out_free  = !out_valid_q || res.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RECV: if (rx_acc && csum_step && csum_ok) state_d = ST_DUMP;
      ST_DUMP: if (rd_pend_q && idx_q == LastIdx) state_d = ST_RECV;
      default: state_d = ST_RECV;
    endcase
  end

  // outputs: checksum byte waits for an empty output register
  always_comb begin
    rx.ready = (state_q == ST_RECV) && (!csum_step || !out_valid_q);
  end

  // datapath: store fill, sum, replay and output register
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    byte1_d     = byte1_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_pos_d   = out_pos_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;

    if (res.ready) begin
      out_valid_d = 1'b0;
    end

    if (rx_acc) begin
      if (csum_step) begin
        pos_d = '0;
        sum_d = '0;
        idx_d = '0;
        if (csum_ok) begin
          kind_d = classify(byte1_q, cfg);
        end else begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_pos_d   = '0;
          out_kind_d  = KIND_CSUM_ERR;
          out_last_d  = 1'b1;
        end
      end else if (pos_q != '0 || hdr_ok) begin
        mem_wr_en = 1'b1;
        pos_d     = pos_q + PosW'(1);
        sum_d     = sum_q + rx.rx_byte;
        if (pos_q == PosW'(1)) begin
          byte1_d = rx.rx_byte;
        end
      end
    end

    // replay: read one entry, load it the cycle after
    if (state_q == ST_DUMP) begin
      if (rd_pend_q) begin
        out_valid_d = 1'b1;
        out_byte_d  = rd_data_q;
        out_pos_d   = idx_q;
        out_kind_d  = kind_q;
        out_last_d  = (idx_q == LastIdx);
        idx_d       = idx_q + AddrW'(1);
        rd_pend_d   = 1'b0;
      end else if (out_free) begin
        mem_rd_en = 1'b1;
        rd_pend_d = 1'b1;
      end
    end
  end

  // frame store: fill and replay never overlap, so no forwarding
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      store_mem[pos_q[AddrW-1:0]] <= rx.rx_byte;
    end
    if (mem_rd_en) begin
      rd_data_q <= store_mem[idx_q];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RECV;
      pos_q       <= '0;
      sum_q       <= '0;
      kind_q      <= KIND_WRITE;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte1_q    <= byte1_d;
    out_byte_q <= out_byte_d;
    out_pos_q  <= out_pos_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign res.valid         = out_valid_q;
  assign res.frame_byte    = out_byte_q;
  assign res.byte_position = PosOutW'(out_pos_q);
  assign res.frame_kind    = out_kind_q;
  assign res.last          = out_last_q;

endmodule

FILE: tb/sv/tb_header_sum_checked_frame_receiver.sv
module tb_header_sum_checked_frame_receiver;
  import hsfr_pkg::*;

  localparam int unsigned FRAME_LEN   = FrameLenDef;
  localparam int unsigned STORE_LEN   = FRAME_LEN - 1;
  // Quiet wait covers a full replay of the stored bytes, plus some margin
  localparam int unsigned QUIET_WAIT  = 2 * STORE_LEN + 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_BYTES = 12;
  localparam int unsigned NUM_PHASES  = 5;
  localparam int unsigned PRESS_PHASE = 4;

  // What kind of byte sequence to put on the line
  typedef enum int unsigned {
    PLAN_WRITE,
    PLAN_READ,
    PLAN_OTHER,
    PLAN_BAD_SUM,
    PLAN_CUT
  } frame_plan_e;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [PosOutW-1:0] pos;
    frame_kind_e        kind;
    logic               last;
  } frame_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  hsfr_rx_if  rx_if ();
  hsfr_res_if res_if ();

  header_sum_checked_frame_receiver #(
    .FRAME_LEN(FRAME_LEN)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx_if),
    .res    (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow of the block's registers and frame state
  hsfr_cfg_t        cfg_shadow = '{HeaderByteRst, WriteCodeRst, ReadCodeRst};
  logic [5:0]       frame_pos  = '0;
  logic [ByteW-1:0] frame_sum  = '0;
  logic [ByteW-1:0] frame_buf [STORE_LEN];

  logic [ByteW-1:0] line_bytes_q [$];
  frame_out_t       exp_frame_out_q [$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold      = 1'b0;
  int unsigned phase_no       = 0;
  int unsigned err_cnt        = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned bytes_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned good_frames    = 0;
  int unsigned bad_frames     = 0;
  int unsigned frame_bytes_added = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Follow one accepted line byte, queueing whatever results it releases
  function automatic void track_rx_byte(input logic [ByteW-1:0] b);
    frame_kind_e kind;
    frame_out_t  item;
    if (frame_pos == 0 && b != cfg_shadow.header_byte) begin
      return;
    end
    if (frame_pos >= STORE_LEN) begin
      frame_pos = '0;
      if (frame_sum == b) begin
        // write code is tested first, so equal codes give a write
        if (frame_buf[1] == cfg_shadow.write_code) begin
          kind = KIND_WRITE;
        end else if (frame_buf[1] == cfg_shadow.read_code) begin
          kind = KIND_READ;
        end else begin
          kind = KIND_OTHER;
        end
        for (int i = 0; i < STORE_LEN; i++) begin
          item.data = frame_buf[i];
          item.pos  = PosOutW'(i);
          item.kind = kind;
          item.last = (i == STORE_LEN - 1);
          exp_frame_out_q.push_back(item);
        end
      end else begin
        item.data = '0;
        item.pos  = '0;
        item.kind = KIND_CSUM_ERR;
        item.last = 1'b1;
        exp_frame_out_q.push_back(item);
      end
      frame_sum = '0;
      return;
    end
    frame_buf[frame_pos] = b;
    frame_pos = frame_pos + 6'd1;
    frame_sum = frame_sum + b;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt < 40) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  // Line byte driver, fed from line_bytes_q
  always @(posedge clk_i or negedge rst_ni) begin : rx_driver
    logic holding;
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
    end else begin
      holding = rx_if.valid && !rx_if.ready;
      if (rx_if.valid && rx_if.ready) begin
        track_rx_byte(rx_if.rx_byte);
        bytes_taken++;
      end
      if (!holding) begin
        if (line_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= line_bytes_q.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin : res_monitor
    frame_out_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (exp_frame_out_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected request, expected none, actual byte %0h pos %0d kind %0d last %0b",
                   $time, res_if.frame_byte, res_if.byte_position, res_if.frame_kind,
                   res_if.last);
        end else begin
          want = exp_frame_out_q.pop_front();
          check_field("frame_byte", want.data, res_if.frame_byte);
          check_field("byte_position", 8'(want.pos), 8'(res_if.byte_position));
          check_field("frame_kind", 8'(want.kind), 8'(res_if.frame_kind));
          check_field("last", 8'(want.last), 8'(res_if.last));
          if (want.kind == KIND_CSUM_ERR) begin
            bad_frames++;
          end else if (want.last) begin
            good_frames++;
          end
        end
      end
      res_if.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Long output hold-off so the block backs up and stalls its input
  initial begin : long_hold
    wait (phase_no == PRESS_PHASE);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d requests still expected", $time,
               exp_frame_out_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic apb_reg_write(input reg_idx_e idx, input logic [ByteW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ApbDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEADER:     cfg_shadow.header_byte = val;
      REG_WRITE_CODE: cfg_shadow.write_code  = val;
      REG_READ_CODE:  cfg_shadow.read_code   = val;
      default: ;
    endcase
  endtask

  // Header, command, random body and a checksum that fits the plan
  task automatic queue_frame(input frame_plan_e plan);
    logic [ByteW-1:0] body [STORE_LEN];
    logic [ByteW-1:0] sum;
    int unsigned      keep;
    body[0] = cfg_shadow.header_byte;
    for (int i = 1; i < STORE_LEN; i++) body[i] = ByteW'($urandom_range(255));
    case (plan)
      PLAN_WRITE: body[1] = cfg_shadow.write_code;
      PLAN_READ:  body[1] = cfg_shadow.read_code;
      default: begin
        while (body[1] == cfg_shadow.write_code || body[1] == cfg_shadow.read_code)
          body[1] = ByteW'($urandom_range(255));
      end
    endcase
    sum = '0;
    for (int i = 0; i < STORE_LEN; i++) sum = sum + body[i];
    // a cut frame stops short, so its successor lands inside it
    keep = (plan == PLAN_CUT) ? $urandom_range(1, STORE_LEN - 1) : STORE_LEN;
    for (int i = 0; i < keep; i++) line_bytes_q.push_back(body[i]);
    if (plan == PLAN_BAD_SUM) begin
      line_bytes_q.push_back(sum + ByteW'($urandom_range(1, 255)));
    end else if (plan != PLAN_CUT) begin
      line_bytes_q.push_back(sum);
    end
    frame_bytes_added += keep + ((plan == PLAN_CUT) ? 0 : 1);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    while (line_bytes_q.size() != 0 || rx_if.valid || exp_frame_out_q.size() != 0)
      @(negedge clk_i);
    repeat (QUIET_WAIT) @(negedge clk_i);
  endtask

  // Main sequence
  initial begin : main_seq
    int unsigned      pick;
    int unsigned      target;
    logic [ByteW-1:0] noise;
    logic [ByteW-1:0] dsum;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Idling mix and register setting for this phase
      @(negedge clk_i);
      case (p)
        1: begin
          src_idle_pct = 60; sink_stall_pct = 0;
          apb_reg_write(REG_HEADER, 8'h00);
          apb_reg_write(REG_WRITE_CODE, 8'hFF);
          apb_reg_write(REG_READ_CODE, 8'h00);
        end
        2: begin
          src_idle_pct = 0; sink_stall_pct = 60;
          apb_reg_write(REG_HEADER, 8'hFF);
          apb_reg_write(REG_WRITE_CODE, 8'h00);
          apb_reg_write(REG_READ_CODE, 8'hFF);
        end
        3: begin
          // equal codes: write must win
          src_idle_pct = 33; sink_stall_pct = 33;
          apb_reg_write(REG_HEADER, 8'h3C);
          apb_reg_write(REG_WRITE_CODE, 8'h77);
          apb_reg_write(REG_READ_CODE, 8'h77);
        end
        4: begin
          src_idle_pct = 0; sink_stall_pct = 0;
          apb_reg_write(REG_HEADER, ByteW'($urandom_range(255)));
          apb_reg_write(REG_WRITE_CODE, ByteW'($urandom_range(255)));
          apb_reg_write(REG_READ_CODE, ByteW'($urandom_range(255)));
        end
        default: begin
          src_idle_pct = 0; sink_stall_pct = 0;
        end
      endcase
      @(negedge clk_i);
      phase_no = p;

      // Phase openers
      case (p)
        0: begin
          // idle junk, then a write frame of extreme bytes whose sum wraps
          line_bytes_q.push_back(8'h00);
          line_bytes_q.push_back(8'hFF);
          line_bytes_q.push_back(8'h5A);
          line_bytes_q.push_back(cfg_shadow.header_byte);
          line_bytes_q.push_back(cfg_shadow.write_code);
          line_bytes_q.push_back(8'h00);
          dsum = cfg_shadow.header_byte + cfg_shadow.write_code;
          for (int i = 3; i < STORE_LEN; i++) begin
            line_bytes_q.push_back(8'hFF);
            dsum = dsum + 8'hFF;
          end
          line_bytes_q.push_back(dsum);
          frame_bytes_added += FRAME_LEN;
        end
        1: begin
          queue_frame(PLAN_BAD_SUM);
          queue_frame(PLAN_OTHER);
        end
        2: queue_frame(PLAN_READ);
        3: queue_frame(PLAN_READ);
        4: begin
          queue_frame(PLAN_WRITE);
          queue_frame(PLAN_READ);
          queue_frame(PLAN_WRITE);
        end
        default: ;
      endcase

      // Mostly well-formed frames, some junk, bad sums and cut frames
      target = frame_bytes_added + PHASE_BYTES;
      while (frame_bytes_added < target) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          repeat ($urandom_range(1, 3)) begin
            noise = ByteW'($urandom_range(255));
            while (noise == cfg_shadow.header_byte) noise = ByteW'($urandom_range(255));
            line_bytes_q.push_back(noise);
          end
        end else if (pick < 45) begin
          queue_frame(PLAN_WRITE);
        end else if (pick < 65) begin
          queue_frame(PLAN_READ);
        end else if (pick < 80) begin
          queue_frame(PLAN_OTHER);
        end else if (pick < 92) begin
          queue_frame(PLAN_BAD_SUM);
        end else begin
          queue_frame(PLAN_CUT);
        end
      end
      wait_quiet();
    end

    $display("Run covered %0d line bytes over %0d idling and register phases,",
             bytes_taken, NUM_PHASES);
    $display("%0d requests checked: %0d good frames, %0d checksum errors, one %0d-cycle hold",
             results_seen, good_frames, bad_frames, HOLD_CYCLES);
    if (err_cnt == 0 && exp_frame_out_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/hsfr_pkg.sv
hdl/hsfr_rx_if.sv
hdl/hsfr_res_if.sv
hdl/hsfr_cfg_regs.sv
hdl/header_sum_checked_frame_receiver.sv
tb/sv/tb_header_sum_checked_frame_receiver.sv
